### rtl/bgai_pkg.sv
// Shared types and constants for the battery gauge averaging and lookup block.
// Holds field widths, register map, charge table and the serial unit status type.
// Used by every module in rtl/.
`timescale 1ns / 1ps
`default_nettype none

package bgai_pkg;

	// Group and conversion settings
	localparam int SAMPLES      = 10;
	localparam int RESOLUTION   = 12;
	localparam int TABLE_POINTS = 10;

	// Field widths
	localparam int SAMPLE_W = 13;
	localparam int AVG_W    = 13;
	localparam int CONV_W   = 14;
	localparam int CELL_W   = 16;
	localparam int PCT_W    = 7;
	localparam int SUM_W    = 20;
	localparam int CNT_W    = 6;
	localparam int SEG_W    = $clog2(TABLE_POINTS);

	// Register widths and reset values
	localparam int FS_W  = 13;
	localparam int RES_W = 12;
	localparam logic [FS_W-1:0]  FULL_SCALE_RST = 13'd3600;
	localparam logic [RES_W-1:0] HIGH_SIDE_RST  = 12'd1000;
	localparam logic [RES_W-1:0] LOW_SIDE_RST   = 12'd510;

	// Register map (word index = paddr[3:2])
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_FULL_SCALE = 2'd0;
	localparam logic [1:0] REG_HIGH_SIDE  = 2'd1;
	localparam logic [1:0] REG_LOW_SIDE   = 2'd2;

	// Serial multiplier: MCAND_W x MPLIER_W, one multiplier bit per cycle
	localparam int MCAND_W   = 14;
	localparam int MPLIER_W  = 13;
	localparam int PROD_W    = MCAND_W + MPLIER_W;
	localparam int MUL_CNT_W = $clog2(MPLIER_W + 1);

	// Serial divider: restoring, one quotient bit per cycle
	localparam int DVD_W     = PROD_W;
	localparam int DVS_W     = 12;
	localparam int DIV_CNT_W = $clog2(DVD_W + 1);

	// Converter rounding and saturation
	localparam logic [PROD_W:0] CEIL_ADD     = (PROD_W+1)'((1 << RESOLUTION) - 1);
	localparam logic [PROD_W:0] CONV_POS_LIM = (PROD_W+1)'((1 << (CONV_W - 1)) - 1);
	localparam logic [PROD_W:0] CONV_NEG_LIM = (PROD_W+1)'(1 << (CONV_W - 1));

	// Charge table, highest voltage first
	localparam logic [CELL_W-1:0] KNEE_MV [TABLE_POINTS] = '{
		16'd4150, 16'd4050, 16'd3950, 16'd3850, 16'd3750,
		16'd3650, 16'd3550, 16'd3500, 16'd3450, 16'd3400
	};
	localparam logic [PCT_W-1:0] KNEE_PCT [TABLE_POINTS] = '{
		7'd100, 7'd92, 7'd84, 7'd73, 7'd64,
		7'd48, 7'd24, 7'd15, 7'd6, 7'd0
	};

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

`default_nettype wire

### rtl/battery_gauge_average_interpolate.sv
// Battery gauge top level: sample accumulation, result sequencer, APB registers.
// Depends on bgai_pkg, bgai_mul and bgai_div.
`timescale 1ns / 1ps
`default_nettype none

// A sample word is taken while no group result is being worked out. The word
// that completes a group of SAMPLES starts the result sequence, during which
// s_tready stays low. Each serial step starts its unit, which works through
// its operand bits, and then picks up the result. The steps in order are:
// divide by SAMPLES, converter multiply, divider multiply and divide, table
// select, interpolation multiply and divide, and loading the output register.
// The multiplies and divides use the shared bit-serial multiplier and divider
// that retire one bit per cycle. At the table ends the last multiply and
// divide are skipped. The load waits while the output register still holds an
// unaccepted word. A finished result waits in the output register while the
// next group's samples are taken.
module battery_gauge_average_interpolate (
	input  wire                               clk,
	input  wire                               arst_n,
	// s_tdata: [12:0] sample
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [15:0]                       s_tdata,
	// m_tdata: [12:0] average_counts, [26:13] converter_mv, [42:27] cell_mv,
	//          [43] went_negative, [50:44] charge_percent
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [55:0]                       m_tdata,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [bgai_pkg::ADDR_W-1:0]       paddr,
	input  wire  [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG,
		ST_CONV,
		ST_CELL_MUL,
		ST_CELL_DIV,
		ST_LOOKUP,
		ST_PCT_MUL,
		ST_PCT_DIV,
		ST_FIN
	} state_t;

	// Configuration registers
	logic [bgai_pkg::FS_W-1:0]  full_scale_q;
	logic [bgai_pkg::RES_W-1:0] high_side_q;
	logic [bgai_pkg::RES_W-1:0] low_side_q;
	logic                       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= bgai_pkg::FULL_SCALE_RST;
			high_side_q  <= bgai_pkg::HIGH_SIDE_RST;
			low_side_q   <= bgai_pkg::LOW_SIDE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				bgai_pkg::REG_FULL_SCALE: full_scale_q <= pwdata[bgai_pkg::FS_W-1:0];
				bgai_pkg::REG_HIGH_SIDE:  high_side_q  <= pwdata[bgai_pkg::RES_W-1:0];
				bgai_pkg::REG_LOW_SIDE:   low_side_q   <= pwdata[bgai_pkg::RES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			bgai_pkg::REG_FULL_SCALE: prdata = 32'(full_scale_q);
			bgai_pkg::REG_HIGH_SIDE:  prdata = 32'(high_side_q);
			bgai_pkg::REG_LOW_SIDE:   prdata = 32'(low_side_q);
			default:                  prdata = '0;
		endcase
	end

	// Sequencer state and unit operands
	state_t                            state_q;
	logic signed [bgai_pkg::SUM_W-1:0] sum_q;
	logic [bgai_pkg::CNT_W-1:0]        count_q;
	logic                              neg_q;
	logic [bgai_pkg::AVG_W-1:0]        avg_q;
	logic [bgai_pkg::CONV_W-1:0]       conv_q;
	logic [bgai_pkg::CELL_W-1:0]       cell_q;
	logic                              went_neg_q;
	logic [bgai_pkg::PCT_W-1:0]        pct_q;
	logic [bgai_pkg::SEG_W-1:0]        seg_q;

	logic                              mul_start_q;
	logic [bgai_pkg::MCAND_W-1:0]      mul_a_q;
	logic [bgai_pkg::MPLIER_W-1:0]     mul_b_q;
	logic                              div_start_q;
	logic [bgai_pkg::DVD_W-1:0]        div_n_q;
	logic [bgai_pkg::DVS_W-1:0]        div_d_q;

	// Output register
	logic                              out_valid_q;
	logic [bgai_pkg::AVG_W-1:0]        out_avg_q;
	logic [bgai_pkg::CONV_W-1:0]       out_conv_q;
	logic [bgai_pkg::CELL_W-1:0]       out_cell_q;
	logic                              out_neg_q;
	logic [bgai_pkg::PCT_W-1:0]        out_pct_q;

	logic [bgai_pkg::PROD_W-1:0]       mul_prod;
	logic [bgai_pkg::DVD_W-1:0]        div_quo;
	bgai_pkg::unit_stat_t              mul_stat;
	bgai_pkg::unit_stat_t              div_stat;

	bgai_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.mcand  (mul_a_q),
		.mplier (mul_b_q),
		.prod   (mul_prod),
		.stat   (mul_stat)
	);

	bgai_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_n_q),
		.divisor  (div_d_q),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// Combinational helpers
	logic signed [bgai_pkg::SUM_W-1:0] sum_next;
	logic [bgai_pkg::SUM_W-1:0]        sum_mag;
	logic                              in_take;
	logic                              group_end;
	logic [bgai_pkg::AVG_W-1:0]        avg_mag;
	logic [bgai_pkg::PROD_W:0]         conv_shift;
	logic [bgai_pkg::PROD_W:0]         conv_lim;
	logic [bgai_pkg::MCAND_W-1:0]      conv_mag_c;
	logic [bgai_pkg::RES_W-1:0]        low_eff;
	logic [bgai_pkg::MPLIER_W-1:0]     ratio_sum;
	logic                              cell_neg_c;
	logic [bgai_pkg::CELL_W-1:0]       cell_c;
	logic [bgai_pkg::SEG_W-1:0]        seg_c;
	logic [bgai_pkg::SEG_W-1:0]        seg_nx;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_take   = s_tvalid && s_tready;
	assign group_end = (count_q == bgai_pkg::CNT_W'(bgai_pkg::SAMPLES - 1));

	always_comb begin
		sum_next = sum_q + bgai_pkg::SUM_W'(signed'(s_tdata[bgai_pkg::SAMPLE_W-1:0]));
		sum_mag  = sum_next[bgai_pkg::SUM_W-1] ? bgai_pkg::SUM_W'(-sum_next)
		                                       : bgai_pkg::SUM_W'(sum_next);
		avg_mag  = div_quo[bgai_pkg::AVG_W-1:0];

		// floor of the signed product: round the magnitude up when negative
		conv_shift = neg_q ? (({1'b0, mul_prod} + bgai_pkg::CEIL_ADD) >> bgai_pkg::RESOLUTION)
		                   : ({1'b0, mul_prod} >> bgai_pkg::RESOLUTION);
		conv_lim   = neg_q ? bgai_pkg::CONV_NEG_LIM : bgai_pkg::CONV_POS_LIM;
		conv_mag_c = (conv_shift > conv_lim) ? bgai_pkg::MCAND_W'(conv_lim)
		                                     : bgai_pkg::MCAND_W'(conv_shift);

		low_eff   = (low_side_q == '0) ? bgai_pkg::RES_W'(1) : low_side_q;
		ratio_sum = {1'b0, high_side_q} + {1'b0, low_eff};

		// a negative quotient that truncates to zero is not flagged
		cell_neg_c = neg_q && (div_quo != '0);
		if (cell_neg_c) begin
			cell_c = '0;
		end else if (div_quo[bgai_pkg::DVD_W-1:bgai_pkg::CELL_W] != '0) begin
			cell_c = '1;
		end else begin
			cell_c = div_quo[bgai_pkg::CELL_W-1:0];
		end

		seg_c = '0;
		for (int i = 0; i < bgai_pkg::TABLE_POINTS - 1; i++) begin
			if (cell_q <= bgai_pkg::KNEE_MV[i] && cell_q > bgai_pkg::KNEE_MV[i+1]) begin
				seg_c = bgai_pkg::SEG_W'(i);
			end
		end
		seg_nx = seg_c + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			count_q     <= '0;
			neg_q       <= 1'b0;
			avg_q       <= '0;
			conv_q      <= '0;
			cell_q      <= '0;
			went_neg_q  <= 1'b0;
			pct_q       <= '0;
			seg_q       <= '0;
			mul_start_q <= 1'b0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			div_start_q <= 1'b0;
			div_n_q     <= '0;
			div_d_q     <= '0;
			out_valid_q <= 1'b0;
			out_avg_q   <= '0;
			out_conv_q  <= '0;
			out_cell_q  <= '0;
			out_neg_q   <= 1'b0;
			out_pct_q   <= '0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (out_valid_q && m_tready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (group_end) begin
							sum_q       <= '0;
							count_q     <= '0;
							neg_q       <= sum_next[bgai_pkg::SUM_W-1];
							div_n_q     <= bgai_pkg::DVD_W'(sum_mag);
							div_d_q     <= bgai_pkg::DVS_W'(bgai_pkg::SAMPLES);
							div_start_q <= 1'b1;
							state_q     <= ST_AVG;
						end else begin
							sum_q   <= sum_next;
							count_q <= count_q + 1'b1;
						end
					end
				end
				ST_AVG: begin
					if (div_stat.done) begin
						avg_q       <= neg_q ? bgai_pkg::AVG_W'(-avg_mag) : avg_mag;
						mul_a_q     <= bgai_pkg::MCAND_W'(avg_mag);
						mul_b_q     <= full_scale_q;
						mul_start_q <= 1'b1;
						state_q     <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (mul_stat.done) begin
						conv_q      <= neg_q ? bgai_pkg::CONV_W'(-conv_mag_c)
						                     : bgai_pkg::CONV_W'(conv_mag_c);
						mul_a_q     <= conv_mag_c;
						mul_b_q     <= ratio_sum;
						mul_start_q <= 1'b1;
						state_q     <= ST_CELL_MUL;
					end
				end
				ST_CELL_MUL: begin
					if (mul_stat.done) begin
						div_n_q     <= mul_prod;
						div_d_q     <= low_eff;
						div_start_q <= 1'b1;
						state_q     <= ST_CELL_DIV;
					end
				end
				ST_CELL_DIV: begin
					if (div_stat.done) begin
						cell_q     <= cell_c;
						went_neg_q <= cell_neg_c;
						state_q    <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (cell_q >= bgai_pkg::KNEE_MV[0]) begin
						pct_q   <= bgai_pkg::KNEE_PCT[0];
						state_q <= ST_FIN;
					end else if (cell_q <= bgai_pkg::KNEE_MV[bgai_pkg::TABLE_POINTS-1]) begin
						pct_q   <= bgai_pkg::KNEE_PCT[bgai_pkg::TABLE_POINTS-1];
						state_q <= ST_FIN;
					end else begin
						seg_q       <= seg_c;
						mul_a_q     <= bgai_pkg::MCAND_W'(bgai_pkg::KNEE_MV[seg_c] - cell_q);
						mul_b_q     <= bgai_pkg::MPLIER_W'(bgai_pkg::KNEE_PCT[seg_c]
						                                   - bgai_pkg::KNEE_PCT[seg_nx]);
						mul_start_q <= 1'b1;
						state_q     <= ST_PCT_MUL;
					end
				end
				ST_PCT_MUL: begin
					if (mul_stat.done) begin
						div_n_q     <= mul_prod;
						div_d_q     <= bgai_pkg::DVS_W'(bgai_pkg::KNEE_MV[seg_q]
						                                - bgai_pkg::KNEE_MV[seg_q + 1'b1]);
						div_start_q <= 1'b1;
						state_q     <= ST_PCT_DIV;
					end
				end
				ST_PCT_DIV: begin
					if (div_stat.done) begin
						pct_q   <= bgai_pkg::KNEE_PCT[seg_q] - div_quo[bgai_pkg::PCT_W-1:0];
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_avg_q   <= avg_q;
						out_conv_q  <= conv_q;
						out_cell_q  <= cell_q;
						out_neg_q   <= went_neg_q;
						out_pct_q   <= pct_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_pct_q, out_neg_q, out_cell_q, out_conv_q, out_avg_q};

`ifndef SYNTHESIS
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_stat.busy && div_stat.busy))
		else $error("multiplier and divider busy together");

	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result word raised outside the final step");

	a_neg_clamps_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_neg_q) |-> (out_cell_q == '0))
		else $error("negative flag with nonzero cell millivolts");

	a_pct_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_pct_q <= bgai_pkg::KNEE_PCT[0]))
		else $error("charge percent above table top");
`endif

endmodule

`default_nettype wire

### rtl/bgai_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on bgai_pkg for operand widths and the unit status type.
`timescale 1ns / 1ps
`default_nettype none

module bgai_mul (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire  [bgai_pkg::MCAND_W-1:0]     mcand,
	input  wire  [bgai_pkg::MPLIER_W-1:0]    mplier,
	output logic [bgai_pkg::PROD_W-1:0]      prod,
	output bgai_pkg::unit_stat_t             stat
);

	logic [bgai_pkg::PROD_W-1:0]    acc_q;
	logic [bgai_pkg::PROD_W-1:0]    mcand_q;
	logic [bgai_pkg::MPLIER_W-1:0]  mplier_q;
	logic [bgai_pkg::MUL_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			mcand_q  <= '0;
			mplier_q <= '0;
			cnt_q    <= '0;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				acc_q    <= '0;
				mcand_q  <= bgai_pkg::PROD_W'(mcand);
				mplier_q <= mplier;
				cnt_q    <= bgai_pkg::MUL_CNT_W'(bgai_pkg::MPLIER_W);
				busy_q   <= 1'b1;
			end else if (busy_q) begin
				// add the shifted multiplicand for each set multiplier bit
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				cnt_q    <= cnt_q - 1'b1;
				if (cnt_q == bgai_pkg::MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign prod      = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

### rtl/bgai_div.sv
// Bit-serial restoring divider for unsigned operands, one quotient bit per cycle.
// Depends on bgai_pkg for operand widths and the unit status type.
`timescale 1ns / 1ps
`default_nettype none

module bgai_div (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire  [bgai_pkg::DVD_W-1:0]       dividend,
	input  wire  [bgai_pkg::DVS_W-1:0]       divisor,
	output logic [bgai_pkg::DVD_W-1:0]       quotient,
	output bgai_pkg::unit_stat_t             stat
);

	logic [bgai_pkg::DVD_W-1:0]     quo_q;
	logic [bgai_pkg::DVS_W-1:0]     rem_q;
	logic [bgai_pkg::DVS_W-1:0]     dvs_q;
	logic [bgai_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [bgai_pkg::DVS_W:0] trial;
	logic [bgai_pkg::DVS_W:0] diff;
	logic                     fits;

	always_comb begin
		trial = {rem_q, quo_q[bgai_pkg::DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q  <= dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
				cnt_q  <= bgai_pkg::DIV_CNT_W'(bgai_pkg::DVD_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// dividend bits leave at the top, quotient bits enter at the bottom
				rem_q <= fits ? diff[bgai_pkg::DVS_W-1:0] : trial[bgai_pkg::DVS_W-1:0];
				quo_q <= {quo_q[bgai_pkg::DVD_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == bgai_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

### bench/tb_battery_gauge_average_interpolate.sv
// Self-checking bench for the battery gauge averaging and charge lookup block.
// Drives sample words and APB register writes, predicts each group result in a
// scoreboard class and compares it field by field. Depends on rtl/bgai_pkg.sv.
`timescale 1ns / 1ps

module tb_battery_gauge_average_interpolate;
	import bgai_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 200;
	localparam int PHASES         = 10;
	localparam int PHASE_SAMPLES  = 113;
	localparam int MAX_REPORTS    = 10;
	localparam int MAX_GAP        = 13;
	localparam int SAMPLE_MAX     = 4095;
	localparam int SAMPLE_MIN     = -4096;
	localparam int CONV_MAX       = 8191;
	localparam int CONV_MIN       = -8192;
	localparam int CELL_MAX       = 65535;
	localparam logic [1:0] REG_SPARE = 2'd3;

	// m_tdata field positions, lowest first
	localparam int CONV_LSB = AVG_W;
	localparam int CELL_LSB = CONV_LSB + CONV_W;
	localparam int NEG_BIT  = CELL_LSB + CELL_W;
	localparam int PCT_LSB  = NEG_BIT + 1;

	typedef struct packed {
		logic signed [AVG_W-1:0]  average;
		logic signed [CONV_W-1:0] conv_mv;
		logic [CELL_W-1:0]        cell_mv;
		logic                     negative;
		logic [PCT_W-1:0]         percent;
	} reading_t;

	class gauge_scoreboard;
		logic [FS_W-1:0]  full_scale;
		logic [RES_W-1:0] high_side;
		logic [RES_W-1:0] low_side;
		int group_sum;
		int group_count;
		reading_t expected_readings[$];
		int mismatches;

		function new();
			full_scale = FULL_SCALE_RST;
			high_side = HIGH_SIDE_RST;
			low_side = LOW_SIDE_RST;
			group_sum = 0;
			group_count = 0;
			mismatches = 0;
		endfunction

		function void write_register(logic [1:0] index, logic [31:0] value);
			case (index)
			REG_FULL_SCALE: full_scale = value[FS_W-1:0];
			REG_HIGH_SIDE: high_side = value[RES_W-1:0];
			REG_LOW_SIDE: low_side = value[RES_W-1:0];
			default: ;
			endcase
		endfunction

		function logic [31:0] register_value(logic [1:0] index);
			case (index)
			REG_FULL_SCALE: return 32'(full_scale);
			REG_HIGH_SIDE: return 32'(high_side);
			REG_LOW_SIDE: return 32'(low_side);
			default: return '0;
			endcase
		endfunction

		function int low_side_used();
			return (low_side == 0) ? 1 : int'(low_side);
		endfunction

		function logic [PCT_W-1:0] charge_from_cell(int mv);
			int i;
			int dv;
			int dp;
			int off;
			if (mv >= int'(KNEE_MV[0]))
				return KNEE_PCT[0];
			if (mv <= int'(KNEE_MV[TABLE_POINTS-1]))
				return KNEE_PCT[TABLE_POINTS-1];
			for (i = 0; i < TABLE_POINTS - 1; i++) begin
				if (mv <= int'(KNEE_MV[i]) && mv > int'(KNEE_MV[i+1])) begin
					dv = int'(KNEE_MV[i]) - int'(KNEE_MV[i+1]);
					dp = int'(KNEE_PCT[i]) - int'(KNEE_PCT[i+1]);
					off = int'(KNEE_MV[i]) - mv;
					return PCT_W'(int'(KNEE_PCT[i]) - off * dp / dv);
				end
			end
			return '0;
		endfunction

		// Accumulate one accepted sample; a completed group queues one reading.
		function void note_sample(logic signed [SAMPLE_W-1:0] s);
			reading_t r;
			int avg;
			int conv;
			int low;
			int scaled;
			int cell_val;
			group_sum += s;
			group_count++;
			if (group_count < SAMPLES)
				return;
			avg = group_sum / SAMPLES;
			group_sum = 0;
			group_count = 0;
			// arithmetic shift of a signed product floors toward minus infinity
			conv = (avg * int'(full_scale)) >>> RESOLUTION;
			if (conv > CONV_MAX)
				conv = CONV_MAX;
			if (conv < CONV_MIN)
				conv = CONV_MIN;
			low = low_side_used();
			scaled = conv * (int'(high_side) + low) / low;
			cell_val = (scaled < 0) ? 0 : (scaled > CELL_MAX) ? CELL_MAX : scaled;
			r.average = AVG_W'(avg);
			r.conv_mv = CONV_W'(conv);
			r.cell_mv = CELL_W'(cell_val);
			r.negative = (scaled < 0);
			r.percent = charge_from_cell(cell_val);
			expected_readings.push_back(r);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t mismatch %s: expected %0d, got %0d", $realtime, name,
						want, got);
			end
		endfunction

		function void check_result(logic [55:0] word);
			reading_t got;
			reading_t want;
			got.average = word[AVG_W-1:0];
			got.conv_mv = word[CONV_LSB +: CONV_W];
			got.cell_mv = word[CELL_LSB +: CELL_W];
			got.negative = word[NEG_BIT];
			got.percent = word[PCT_LSB +: PCT_W];
			if (expected_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t unexpected result word %h", $realtime, word);
				return;
			end
			want = expected_readings.pop_front();
			compare_field("average_counts", want.average, got.average);
			compare_field("converter_mv", want.conv_mv, got.conv_mv);
			compare_field("cell_mv", want.cell_mv, got.cell_mv);
			compare_field("went_negative", want.negative, got.negative);
			compare_field("charge_percent", want.percent, got.percent);
		endfunction

		function int outstanding();
			return expected_readings.size();
		endfunction

		function void flag_leftovers();
			if (expected_readings.size() != 0) begin
				mismatches++;
				$display("%0d expected results never arrived", expected_readings.size());
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	gauge_scoreboard board = new();
	bit src_eager = 1'b0;
	bit sink_eager = 1'b0;
	int sink_stall = 0;
	int next_stall;
	int idle_cycles = 0;

	battery_gauge_average_interpolate dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: stall a random number of cycles before each word, with
	// stretches of back-to-back acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_stall <= 0;
		end else if (m_tvalid && m_tready) begin
			board.check_result(m_tdata);
			if ($urandom_range(0, 7) == 0)
				sink_eager = ~sink_eager;
			next_stall = sink_eager ? 0 : int'($urandom_range(0, MAX_GAP));
			sink_stall <= next_stall;
			m_tready <= (next_stall == 0);
		end else if (sink_stall > 0) begin
			sink_stall <= sink_stall - 1;
			m_tready <= (sink_stall == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int clip_sample(int v);
		return (v > SAMPLE_MAX) ? SAMPLE_MAX : (v < SAMPLE_MIN) ? SAMPLE_MIN : v;
	endfunction

	// Hold each word until accepted; keep tvalid high when the next gap is zero.
	task automatic send_sample(int value);
		int gap;
		gap = src_eager ? 0 : int'($urandom_range(0, MAX_GAP));
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(16 - SAMPLE_W){1'b0}}, SAMPLE_W'(value)};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_sample(SAMPLE_W'(value));
	endtask

	task automatic apb_write(logic [1:0] index, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({index, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		board.write_register(index, data);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_readback(logic [1:0] index);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_W'({index, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		board.compare_field("register readback", board.register_value(index), prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Drop tvalid, wait out every pending result, then let the block settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.outstanding() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write a register, sometimes with junk above its width, and read it back.
	task automatic set_register(logic [1:0] index, int value, int width);
		logic [31:0] junk;
		junk = $urandom_range(0, 1) ? ($urandom << width) : 32'd0;
		apb_write(index, 32'(value) | junk);
		apb_readback(index);
	endtask

	task automatic configure(int phase);
		int fs;
		int hi;
		int lo;
		case (phase)
		0: begin
			fs = FULL_SCALE_RST;
			hi = HIGH_SIDE_RST;
			lo = LOW_SIDE_RST;
		end
		1: begin
			fs = 8191;
			hi = 4095;
			lo = 1;
		end
		2: begin
			fs = 1;
			hi = 0;
			lo = 4095;
		end
		3: begin
			// zero low side acts as one
			fs = 3300;
			hi = 1000;
			lo = 0;
		end
		default: begin
			fs = $urandom_range(0, 1) ? $urandom_range(2500, 4500) : $urandom_range(1, 8191);
			hi = $urandom_range(0, 4095);
			lo = $urandom_range(0, 4095);
		end
		endcase
		set_register(REG_FULL_SCALE, fs, FS_W);
		set_register(REG_HIGH_SIDE, hi, RES_W);
		set_register(REG_LOW_SIDE, lo, RES_W);
		// unmapped index must leave the map untouched
		apb_write(REG_SPARE, $urandom);
		apb_readback(REG_LOW_SIDE);
	endtask

	// Average that lands the cell voltage near a goal under the current registers.
	function automatic int aim_average(int cell_goal);
		int low;
		int conv;
		low = board.low_side_used();
		conv = cell_goal * low / (int'(board.high_side) + low);
		return clip_sample((conv <<< RESOLUTION) / int'(board.full_scale));
	endfunction

	task automatic run_phase();
		int left;
		int kind;
		int center;
		int spread;
		int k;
		left = PHASE_SAMPLES;
		while (left > 0) begin
			kind = $urandom_range(0, 19);
			spread = $urandom_range(0, 24);
			if (kind < 12)
				center = aim_average($urandom_range(3300, 4250));
			else
				center = int'($urandom_range(0, 8191)) - 4096;
			for (k = 0; k < SAMPLES && left > 0; k++) begin
				if (kind >= 16)
					send_sample(int'($urandom_range(0, 8191)) - 4096);
				else
					send_sample(clip_sample(center + int'($urandom_range(0, 2 * spread)) - spread));
				left--;
			end
		end
	endtask

	initial begin
		int phase;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full-scale groups at both ends, then a partial group left open
		src_eager = 1'b1;
		repeat (SAMPLES) send_sample(SAMPLE_MAX);
		src_eager = 1'b0;
		repeat (SAMPLES) send_sample(SAMPLE_MIN);
		send_sample(-7);
		send_sample(2);
		send_sample(0);

		for (phase = 0; phase < PHASES; phase++) begin
			drain();
			configure(phase);
			src_eager = ($urandom_range(0, 2) == 0);
			run_phase();
		end
		drain();

		board.flag_leftovers();
		if (board.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### filelist.f
rtl/bgai_pkg.sv
rtl/bgai_mul.sv
rtl/bgai_div.sv
rtl/battery_gauge_average_interpolate.sv
bench/tb_battery_gauge_average_interpolate.sv
